### rtl/thl_pkg.sv
package thl_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int STORE_AW     = 16;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int FRONT_STAGES = 5;
  localparam int INFLIGHT_W   = $clog2(FRONT_STAGES + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_DEPTH    = 3'd1,
    REG_CELL_SPACING  = 3'd2,
    REG_CELL_INVERSE  = 3'd3,
    REG_HEIGHT_GAIN   = 3'd4,
    REG_HEIGHT_BIAS   = 3'd5
  } cfg_reg_t;

  localparam logic [8:0]  RST_GRID_WIDTH   = 9'd256;
  localparam logic [8:0]  RST_GRID_DEPTH   = 9'd256;
  localparam logic [20:0] RST_CELL_SPACING = 21'd13107;
  localparam logic [24:0] RST_CELL_INVERSE = 25'd327680;
  localparam logic [23:0] RST_HEIGHT_GAIN  = 24'd6554;
  localparam logic [31:0] RST_HEIGHT_BIAS  = 32'hFFFB_0000;

  typedef struct packed {
    logic [8:0]  grid_width;
    logic [8:0]  grid_depth;
    logic [20:0] cell_spacing;
    logic [24:0] cell_spacing_inverse;
    logic [23:0] height_gain;
    logic [31:0] height_bias;
  } cfg_t;

  // One word on its way from the classifier to the lookup side.
  typedef struct packed {
    op_t                 operation;
    logic [7:0]          sample_value;
    logic [15:0]         sample_index;
    logic                off_grid;
    logic                lower_triangle;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_z;
    logic [STORE_AW-1:0] corner_index;
  } item_t;

endpackage

### rtl/thl_store.sv
module thl_store import thl_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [STORE_AW-1:0] waddr,
  input  logic [7:0]          wdata,
  input  logic [STORE_AW-1:0] raddr_a,
  input  logic [STORE_AW-1:0] raddr_b,
  output logic [7:0]          rdata_a,
  output logic [7:0]          rdata_b
);

  logic [7:0] mem [0:(1 << STORE_AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/thl_queue.sv
module thl_queue import thl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  item_t               push_item,
  input  logic                pop,
  output logic                head_valid,
  output item_t               head_item,
  output logic [QUEUE_AW:0]   count
);

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

endmodule

### rtl/thl_front.sv
module thl_front import thl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  take,
  input  op_t                   operation,
  input  logic [7:0]            sample_value,
  input  logic [15:0]           sample_index,
  input  logic [31:0]           world_x,
  input  logic [31:0]           world_z,
  output logic                  push,
  output item_t                 push_item,
  output logic [INFLIGHT_W-1:0] inflight
);

  localparam int LOC_W   = 34;
  localparam int SPLIT   = 16;               // inverse split into low/high parts
  localparam int PL_W    = LOC_W + SPLIT + 1;
  localparam int PH_W    = LOC_W + 25 - SPLIT + 1;
  localparam int PX_W    = 60;
  localparam int CELL_W  = PX_W - 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // half extents, refreshed every cycle from the registers
  logic [28:0] half_w;
  logic [28:0] half_d;

  always_ff @(posedge clk) begin
    half_w <= 29'((30'(cfg.grid_width) * 30'(cfg.cell_spacing)) >> 1);
    half_d <= 29'((30'(cfg.grid_depth) * 30'(cfg.cell_spacing)) >> 1);
  end

  // stage 1: capture
  logic        v1, v2, v3, v4, v5;
  op_t         op1, op2, op3, op4;
  logic [7:0]  sv1, sv2, sv3, sv4;
  logic [15:0] si1, si2, si3, si4;
  logic [31:0] wx1, wz1;

  logic signed [LOC_W-1:0] lx2, lz2;
  logic signed [PL_W-1:0]  plx3, plz3;
  logic signed [PH_W-1:0]  phx3, phz3;
  logic signed [PX_W-1:0]  px4, pz4;
  item_t                   item5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op1 <= operation;
      sv1 <= sample_value;
      si1 <= sample_index;
      wx1 <= world_x;
      wz1 <= world_z;
    end
  end

  // stage 2: move to grid-local coordinates
  always_ff @(posedge clk) begin
    op2 <= op1;
    sv2 <= sv1;
    si2 <= si1;
    lx2 <= {{(LOC_W - 32){wx1[31]}}, wx1} + {{(LOC_W - 29){1'b0}}, half_w};
    lz2 <= {{(LOC_W - 29){1'b0}}, half_d} - {{(LOC_W - 32){wz1[31]}}, wz1};
  end

  // stage 3: partial products against the inverse spacing
  always_ff @(posedge clk) begin
    op3  <= op2;
    sv3  <= sv2;
    si3  <= si2;
    plx3 <= lx2 * $signed({1'b0, cfg.cell_spacing_inverse[SPLIT-1:0]});
    plz3 <= lz2 * $signed({1'b0, cfg.cell_spacing_inverse[SPLIT-1:0]});
    phx3 <= lx2 * $signed({1'b0, cfg.cell_spacing_inverse[24:SPLIT]});
    phz3 <= lz2 * $signed({1'b0, cfg.cell_spacing_inverse[24:SPLIT]});
  end

  // stage 4: combine partial products
  always_ff @(posedge clk) begin
    op4 <= op3;
    sv4 <= sv3;
    si4 <= si3;
    px4 <= PX_W'(plx3) + (PX_W'(phx3) <<< SPLIT);
    pz4 <= PX_W'(plz3) + (PX_W'(phz3) <<< SPLIT);
  end

  // stage 5: classify (cell, fraction, triangle, corner index)
  logic [CELL_W-1:0]    cx, cz;
  logic [FRAC_BITS-1:0] fx, fz;
  logic                 off_x, off_z, lower;
  logic [17:0]          corner;

  always_comb begin
    cx     = px4[PX_W-1:2*FRAC_BITS];
    cz     = pz4[PX_W-1:2*FRAC_BITS];
    fx     = px4[2*FRAC_BITS-1:FRAC_BITS];
    fz     = pz4[2*FRAC_BITS-1:FRAC_BITS];
    off_x  = px4[PX_W-1] || (cfg.grid_width == 9'd0)
             || (cx >= CELL_W'(cfg.grid_width - 9'd1));
    off_z  = pz4[PX_W-1] || (cfg.grid_depth == 9'd0)
             || (cz >= CELL_W'(cfg.grid_depth - 9'd1));
    lower  = ((FRAC_BITS + 1)'(fx) + (FRAC_BITS + 1)'(fz)) > ONE;
    corner = 18'(cz[8:0]) * 18'(cfg.grid_width) + 18'(cx[8:0]);
  end

  always_ff @(posedge clk) begin
    item5.operation      <= op4;
    item5.sample_value   <= sv4;
    item5.sample_index   <= si4;
    item5.off_grid       <= off_x || off_z;
    item5.lower_triangle <= lower && !(off_x || off_z);
    item5.frac_x         <= fx;
    item5.frac_z         <= fz;
    item5.corner_index   <= STORE_AW'(corner);
  end

  assign push      = v5;
  assign push_item = item5;
  assign inflight  = INFLIGHT_W'(v1) + INFLIGHT_W'(v2) + INFLIGHT_W'(v3)
                   + INFLIGHT_W'(v4) + INFLIGHT_W'(v5);

endmodule

### rtl/thl_back.sv
module thl_back import thl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  output logic        done,
  output logic [31:0] surface_height,
  output logic        off_grid,
  output logic        lower_triangle
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam int W_W  = FRAC_BITS + 1;
  localparam int M_W  = 34;
  localparam int P_W  = W_W + 1 + M_W;
  localparam int HA_W = 36;
  localparam int S_W  = P_W + 1;
  localparam int H_W  = 38;
  localparam logic signed [S_W-1:0] RND    = S_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [H_W-1:0] SAT_HI = H_W'(32'h7FFF_FFFF);
  localparam logic signed [H_W-1:0] SAT_LO = -(H_W'(33'h1_0000_0000) >>> 1);

  logic                wr, qry;
  logic [STORE_AW-1:0] a0, a1, a2, a3;
  logic [7:0]          r0, r1, r2, r3;

  assign pop = head_valid;
  assign wr  = head_valid && (head_item.operation == OP_LOAD);
  assign qry = head_valid && (head_item.operation == OP_QUERY);

  assign a0 = head_item.corner_index;
  assign a1 = a0 + 1'b1;
  assign a2 = a0 + STORE_AW'(cfg.grid_width);
  assign a3 = a2 + 1'b1;

  // two copies, same writes: four corner reads per cycle
  thl_store u_store_near (
    .clk     (clk),
    .we      (wr),
    .waddr   (head_item.sample_index[STORE_AW-1:0]),
    .wdata   (head_item.sample_value),
    .raddr_a (a0),
    .raddr_b (a1),
    .rdata_a (r0),
    .rdata_b (r1)
  );

  thl_store u_store_far (
    .clk     (clk),
    .we      (wr),
    .waddr   (head_item.sample_index[STORE_AW-1:0]),
    .wdata   (head_item.sample_value),
    .raddr_a (a2),
    .raddr_b (a3),
    .rdata_a (r2),
    .rdata_b (r3)
  );

  logic                 v1, v2, v3, v4;
  logic                 off1, off2, off3, off4;
  logic                 low1, low2, low3, low4;
  logic [FRAC_BITS-1:0] fx1, fz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= qry;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    off1 <= head_item.off_grid;
    low1 <= head_item.lower_triangle;
    fx1  <= head_item.frac_x;
    fz1  <= head_item.frac_z;
  end

  // corner select; bias cancels in the differences
  logic [7:0]        sa, sb, sc;
  logic signed [8:0] db, dc;
  logic [W_W-1:0]    wb, wc;

  always_comb begin
    if (low1) begin
      sa = r3;
      sb = r2;
      sc = r1;
      wb = ONE - W_W'(fx1);
      wc = ONE - W_W'(fz1);
    end else begin
      sa = r0;
      sb = r1;
      sc = r2;
      wb = W_W'(fx1);
      wc = W_W'(fz1);
    end
    db = $signed({1'b0, sb}) - $signed({1'b0, sa});
    dc = $signed({1'b0, sc}) - $signed({1'b0, sa});
  end

  logic signed [M_W-1:0]  mb2, mc2;
  logic [31:0]            hp2;
  logic [W_W-1:0]         wb2, wc2;
  logic signed [P_W-1:0]  pb3, pc3;
  logic signed [HA_W-1:0] ha3, ha4;
  logic signed [S_W-1:0]  s4;
  logic signed [H_W-1:0]  h;

  always_ff @(posedge clk) begin
    off2 <= off1;
    low2 <= low1;
    wb2  <= wb;
    wc2  <= wc;
    mb2  <= db * $signed({1'b0, cfg.height_gain});
    mc2  <= dc * $signed({1'b0, cfg.height_gain});
    hp2  <= 32'(sa) * 32'(cfg.height_gain);

    off3 <= off2;
    low3 <= low2;
    pb3  <= $signed({1'b0, wb2}) * mb2;
    pc3  <= $signed({1'b0, wc2}) * mc2;
    ha3  <= $signed({(HA_W - 32)'(0), hp2}) + HA_W'($signed(cfg.height_bias));

    off4 <= off3;
    low4 <= low3;
    s4   <= S_W'(pb3) + S_W'(pc3) + RND;
    ha4  <= ha3;
  end

  assign h = H_W'(ha4) + H_W'(s4 >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    off_grid       <= off4;
    lower_triangle <= low4;
    if (off4) begin
      surface_height <= '0;
    end else if (h > SAT_HI) begin
      surface_height <= 32'h7FFF_FFFF;
    end else if (h < SAT_LO) begin
      surface_height <= 32'h8000_0000;
    end else begin
      surface_height <= h[31:0];
    end
  end

endmodule

### rtl/terrain_height_lookup.sv
// Terrain height lookup on a regular heightmap. A word with operation = 0 stores one 8-bit
// sample at sample_index; a word with operation = 1 returns the height under (world_x,
// world_z) one result per query and none per load. A new word is taken on every clock edge
// where start is high and busy is low, so the block runs at one word per cycle; busy only
// rises if the internal queue would overflow, which does not happen in steady operation
// since the lookup side never waits. A query's result shows on done/surface_height/
// off_grid/lower_triangle for one cycle, after the front pipe, the queue and the back pipe;
// the receiver cannot stall it, so it must sample done every cycle. Results come out in the
// order the queries went in, and a load is visible to any query taken after it. The
// height store is not cleared at reset: a query that touches a sample never loaded
// returns an undefined height. Registers are written through cfg_write/cfg_index/cfg_data
// and may only change while no query is in flight.
module terrain_height_lookup import thl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  sample_value,
  input  logic [15:0] sample_index,
  input  logic [31:0] world_x,
  input  logic [31:0] world_z,
  // register writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // results
  output logic        done,
  output logic [31:0] surface_height,
  output logic        off_grid,
  output logic        lower_triangle
);

  cfg_t                  cfg;
  logic                  take;
  logic                  push;
  item_t                 push_item;
  logic [INFLIGHT_W-1:0] inflight;
  logic                  pop;
  logic                  head_valid;
  item_t                 head_item;
  logic [QUEUE_AW:0]     q_count;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width           <= RST_GRID_WIDTH;
      cfg.grid_depth           <= RST_GRID_DEPTH;
      cfg.cell_spacing         <= RST_CELL_SPACING;
      cfg.cell_spacing_inverse <= RST_CELL_INVERSE;
      cfg.height_gain          <= RST_HEIGHT_GAIN;
      cfg.height_bias          <= RST_HEIGHT_BIAS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:   cfg.grid_width           <= cfg_data[8:0];
        REG_GRID_DEPTH:   cfg.grid_depth           <= cfg_data[8:0];
        REG_CELL_SPACING: cfg.cell_spacing         <= cfg_data[20:0];
        REG_CELL_INVERSE: cfg.cell_spacing_inverse <= cfg_data[24:0];
        REG_HEIGHT_GAIN:  cfg.height_gain          <= cfg_data[23:0];
        REG_HEIGHT_BIAS:  cfg.height_bias          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off new words only when everything in the front pipe plus the queue
  // could fill the queue.
  assign busy = ((INFLIGHT_W + QUEUE_AW + 1)'(inflight)
               + (INFLIGHT_W + QUEUE_AW + 1)'(q_count))
               >= (INFLIGHT_W + QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign take = start && !busy;

  // Front: grid mapping, cell/fraction split, off-grid and triangle decision.
  thl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .take         (take),
    .operation    (op_t'(operation)),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .world_x      (world_x),
    .world_z      (world_z),
    .push         (push),
    .push_item    (push_item),
    .inflight     (inflight)
  );

  // Short queue between classifier and lookup.
  thl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  // Back: store writes, corner reads, vertex heights, interpolation, saturation.
  thl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .done           (done),
    .surface_height (surface_height),
    .off_grid       (off_grid),
    .lower_triangle (lower_triangle)
  );

endmodule

### verif/tb_terrain_height_lookup.sv
module tb_terrain_height_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import thl_pkg::*;

  // Wait for the result pipe to drain before touching registers, since loads
  // leave nothing in the expected queue.
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 20;
  // Random part: eight register setups, at least PHASE_WORDS words in each.
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 185;
  localparam int RANDOM_WORDS = PHASES * PHASE_WORDS;
  localparam int MAX_REPORTS  = 10;

  localparam longint HEIGHT_MAX = 64'sd2147483647;
  localparam longint HEIGHT_MIN = -64'sd2147483648;
  localparam longint UNIT       = longint'(1) << FRAC_BITS;

  // One result word as seen on the output ports.
  typedef struct packed {
    logic [31:0] height;
    logic        off_grid;
    logic        lower;
  } surface_t;

  localparam surface_t OFF_GRID_RESULT = '{height: 32'd0, off_grid: 1'b1, lower: 1'b0};

  // One line of the directed plan: a load, a query or a register write.
  // Typed rows carry their own answer; the rest go through the predictor.
  typedef struct {
    bit                  is_reg;
    op_t                 op;
    logic [7:0]          val;
    logic [STORE_AW-1:0] idx;
    logic [31:0]         wx;
    logic [31:0]         wz;
    cfg_reg_t            sel;
    logic [31:0]         data;
    bit                  typed;
    surface_t            want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [7:0]  sample_value;
  logic [15:0] sample_index;
  logic [31:0] world_x;
  logic [31:0] world_z;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  logic [31:0] surface_height;
  logic        off_grid;
  logic        lower_triangle;

  terrain_height_lookup DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .sample_value   (sample_value),
    .sample_index   (sample_index),
    .world_x        (world_x),
    .world_z        (world_z),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .surface_height (surface_height),
    .off_grid       (off_grid),
    .lower_triangle (lower_triangle)
  );

  // ---------------------------------------------------------------------
  // Mirror of the block: register file, height store, and which store
  // entries have been written since reset (queries never touch the rest).
  // ---------------------------------------------------------------------
  cfg_t       setup;
  logic [7:0] height_mem [0:(1 << STORE_AW) - 1];
  bit         loaded_mem [0:(1 << STORE_AW) - 1];

  // Heights still owed by the block, oldest first.
  surface_t   pending_heights [$];

  // Directed plan, walked in order.
  plan_row_t  plan_rows [$];

  int idle_pct;
  int sent_words;
  int loads_sent;
  int queries_sent;
  int results_checked;
  int reg_writes;
  int mismatches;

  // Half the grid extent along one axis, Q16.16, rounded down.
  function automatic longint half_span(logic [8:0] count);
    return longint'((64'(count) * 64'(setup.cell_spacing)) >> 1);
  endfunction

  // World point -> grid cell. Reports whether the cell is on the grid, the
  // fractional position inside it, and the four store indices around it.
  function automatic void place_point(input logic [31:0] wx, input logic [31:0] wz,
                                      output bit on_grid, output int fx, output int fz,
                                      output logic [3:0][STORE_AW-1:0] corner);
    longint px, pz, cx, cz, tl, w;
    w  = longint'(setup.grid_width);
    px = (longint'($signed(wx)) + half_span(setup.grid_width))
         * longint'(setup.cell_spacing_inverse);
    pz = (half_span(setup.grid_depth) - longint'($signed(wz)))
         * longint'(setup.cell_spacing_inverse);
    on_grid = 1'b0;
    fx = 0;
    fz = 0;
    corner = '0;
    // negative product: left of / beyond the near edge (floor, not truncation)
    if (px < 0 || pz < 0) return;
    cx = px >>> (2 * FRAC_BITS);
    cz = pz >>> (2 * FRAC_BITS);
    // last row/column has no far neighbor; widths below 2 never qualify
    if (cx >= w - 1 || cz >= longint'(setup.grid_depth) - 1) return;
    fx = int'(px[2*FRAC_BITS-1:FRAC_BITS]);
    fz = int'(pz[2*FRAC_BITS-1:FRAC_BITS]);
    // store address wraps for oversize grids
    tl = cz * w + cx;
    corner[0] = STORE_AW'(tl);
    corner[1] = STORE_AW'(tl + 1);
    corner[2] = STORE_AW'(tl + w);
    corner[3] = STORE_AW'(tl + w + 1);
    on_grid = 1'b1;
  endfunction

  function automatic longint vertex_height(logic [STORE_AW-1:0] at);
    return longint'(height_mem[at]) * longint'(setup.height_gain)
           + longint'($signed(setup.height_bias));
  endfunction

  // Expected result word for a query against the current mirror.
  function automatic surface_t predict_surface(logic [31:0] wx, logic [31:0] wz);
    surface_t r;
    bit on_grid;
    int fx, fz;
    logic [3:0][STORE_AW-1:0] corner;
    longint ha, hb, hc, wb, wc, sum, h;
    r = OFF_GRID_RESULT;
    place_point(wx, wz, on_grid, fx, fz, corner);
    if (!on_grid) return r;
    r.off_grid = 1'b0;
    // fx+fz exactly one stays on the upper-left triangle
    r.lower = (longint'(fx) + longint'(fz)) > UNIT;
    if (!r.lower) begin
      ha = vertex_height(corner[0]);
      hb = vertex_height(corner[1]);
      hc = vertex_height(corner[2]);
      wb = longint'(fx);
      wc = longint'(fz);
    end else begin
      ha = vertex_height(corner[3]);
      hb = vertex_height(corner[2]);
      hc = vertex_height(corner[1]);
      wb = UNIT - longint'(fx);
      wc = UNIT - longint'(fz);
    end
    sum = wb * (hb - ha) + wc * (hc - ha);
    // round half up, then clamp to 32-bit signed
    h = ha + ((sum + (UNIT >>> 1)) >>> FRAC_BITS);
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    if (h < HEIGHT_MIN) h = HEIGHT_MIN;
    r.height = h[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Command side. One word per call; random gaps in front of it, then hold
  // start until the block takes it. Bookkeeping happens at the accepting
  // edge so loads are visible to every later query.
  // ---------------------------------------------------------------------
  task automatic send_word(op_t op, logic [7:0] val, logic [STORE_AW-1:0] idx,
                           logic [31:0] wx, logic [31:0] wz, bit typed, surface_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    sample_value <= val;
    sample_index <= idx;
    world_x      <= wx;
    world_z      <= wz;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_words++;
    if (op == OP_LOAD) begin
      height_mem[idx] = val;
      loaded_mem[idx] = 1'b1;
      loads_sent++;
    end else begin
      pending_heights.insert(pending_heights.size(),
                             typed ? want : predict_surface(wx, wz));
      queries_sent++;
    end
  endtask

  // Query, preceded by loads for any corner the block has never seen.
  // Unused fields of each word carry random junk.
  task automatic issue_query(logic [31:0] wx, logic [31:0] wz, bit typed, surface_t want);
    bit on_grid;
    int fx, fz;
    logic [3:0][STORE_AW-1:0] corner;
    place_point(wx, wz, on_grid, fx, fz, corner);
    if (on_grid) begin
      for (int k = 0; k < 4; k++) begin
        if (!loaded_mem[corner[k]])
          send_word(OP_LOAD, 8'($urandom_range(255)), corner[k], $urandom, $urandom,
                    1'b0, '0);
      end
    end
    send_word(OP_QUERY, 8'($urandom), 16'($urandom), wx, wz, typed, want);
  endtask

  // Register write; only once the pipe is empty and has settled.
  task automatic write_reg(cfg_reg_t sel, logic [31:0] data);
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    case (sel)
      REG_GRID_WIDTH:   setup.grid_width           = data[8:0];
      REG_GRID_DEPTH:   setup.grid_depth           = data[8:0];
      REG_CELL_SPACING: setup.cell_spacing         = data[20:0];
      REG_CELL_INVERSE: setup.cell_spacing_inverse = data[24:0];
      REG_HEIGHT_GAIN:  setup.height_gain          = data[23:0];
      REG_HEIGHT_BIAS:  setup.height_bias          = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Directed plan rows
  // ---------------------------------------------------------------------
  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_reg = 1'b0;
    r.op     = OP_LOAD;
    r.val    = 8'd0;
    r.idx    = '0;
    r.wx     = $urandom;
    r.wz     = $urandom;
    r.sel    = REG_GRID_WIDTH;
    r.data   = 32'd0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t load_row(logic [7:0] val, logic [STORE_AW-1:0] idx);
    plan_row_t r;
    r = blank_row();
    r.val = val;
    r.idx = idx;
    return r;
  endfunction

  function automatic plan_row_t query_row(logic [31:0] wx, logic [31:0] wz);
    plan_row_t r;
    r = blank_row();
    r.op = OP_QUERY;
    r.wx = wx;
    r.wz = wz;
    return r;
  endfunction

  function automatic plan_row_t checked_row(logic [31:0] wx, logic [31:0] wz, surface_t want);
    plan_row_t r;
    r = query_row(wx, wz);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_t sel, logic [31:0] data);
    plan_row_t r;
    r = blank_row();
    r.is_reg = 1'b1;
    r.sel    = sel;
    r.data   = data;
    return r;
  endfunction

  // Append one row to the directed plan.
  function automatic void add_row(plan_row_t r);
    plan_rows.insert(plan_rows.size(), r);
  endfunction

  function automatic cfg_t make_setup(logic [8:0] w, logic [8:0] d, logic [20:0] sp,
                                      logic [24:0] inv, logic [23:0] gain, logic [31:0] bias);
    cfg_t s;
    s.grid_width           = w;
    s.grid_depth           = d;
    s.cell_spacing         = sp;
    s.cell_spacing_inverse = inv;
    s.height_gain          = gain;
    s.height_bias          = bias;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Random phase: program all six registers, then a mix of loads and
  // queries. Most queries aim inside the grid so they reach the
  // interpolation; some hug the edges, the rest are raw 32-bit points.
  // ---------------------------------------------------------------------
  task automatic run_phase(cfg_t s, int random_base);
    int phase_start, pick, progress, cells;
    longint span_x, span_z, lx, lz;
    logic [31:0] wx, wz;
    write_reg(REG_GRID_WIDTH,   32'(s.grid_width));
    write_reg(REG_GRID_DEPTH,   32'(s.grid_depth));
    write_reg(REG_CELL_SPACING, 32'(s.cell_spacing));
    write_reg(REG_CELL_INVERSE, 32'(s.cell_spacing_inverse));
    write_reg(REG_HEIGHT_GAIN,  32'(s.height_gain));
    write_reg(REG_HEIGHT_BIAS,  s.height_bias);
    span_x = longint'(setup.grid_width) * longint'(setup.cell_spacing);
    span_z = longint'(setup.grid_depth) * longint'(setup.cell_spacing);
    cells  = int'(setup.grid_width) * int'(setup.grid_depth);
    phase_start = sent_words;
    while (sent_words - phase_start < PHASE_WORDS) begin
      // sender gaps: 32% for the first third, 55% for the second, none after
      progress = sent_words - random_base;
      idle_pct = (progress < RANDOM_WORDS / 3) ? 32 :
                 (progress < 2 * RANDOM_WORDS / 3) ? 55 : 0;
      pick = $urandom_range(99);
      if (pick < 20) begin
        // reload: anywhere in the store, or somewhere inside the grid
        if ($urandom_range(1) == 0 || cells == 0)
          send_word(OP_LOAD, 8'($urandom), 16'($urandom), $urandom, $urandom, 1'b0, '0);
        else
          send_word(OP_LOAD, 8'($urandom), STORE_AW'($urandom_range(0, cells - 1)),
                    $urandom, $urandom, 1'b0, '0);
      end else begin
        if (pick < 75) begin
          lx = longint'($urandom_range(0, 32'(span_x)));
          lz = longint'($urandom_range(0, 32'(span_z)));
        end else if (pick < 88) begin
          lx = (($urandom_range(1) == 0) ? 0 : span_x)
               + longint'($urandom_range(0, 2 * setup.cell_spacing))
               - longint'(setup.cell_spacing);
          lz = (($urandom_range(1) == 0) ? 0 : span_z)
               + longint'($urandom_range(0, 2 * setup.cell_spacing))
               - longint'(setup.cell_spacing);
        end
        if (pick < 88) begin
          wx = 32'(lx - half_span(setup.grid_width));
          wz = 32'(half_span(setup.grid_depth) - lz);
        end else begin
          wx = $urandom;
          wz = $urandom;
        end
        issue_query(wx, wz, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Result checker: every done strobe must match the oldest expectation.
  // The receiver cannot push back, so sample every cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    surface_t got, want;
    if (!rst && done) begin
      got = '{height: surface_height, off_grid: off_grid, lower: lower_triangle};
      if (pending_heights.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] unexpected result word: height %h off_grid %b lower %b",
                   $realtime, got.height, got.off_grid, got.lower);
        mismatches++;
      end else begin
        want = pending_heights.pop_front();
        results_checked++;
        if (got !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: expected height %h off_grid %b lower %b, got %h %b %b",
                     $realtime, results_checked, want.height, want.off_grid, want.lower,
                     got.height, got.off_grid, got.lower);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int random_base;
    logic [20:0] sp;

    // all inputs known from time zero
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_LOAD;
    sample_value <= 8'd0;
    sample_index <= 16'd0;
    world_x      <= 32'd0;
    world_z      <= 32'd0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_GRID_WIDTH;
    cfg_data     <= 32'd0;

    setup = make_setup(RST_GRID_WIDTH, RST_GRID_DEPTH, RST_CELL_SPACING,
                       RST_CELL_INVERSE, RST_HEIGHT_GAIN, RST_HEIGHT_BIAS);
    foreach (loaded_mem[i]) begin
      loaded_mem[i] = 1'b0;
      height_mem[i] = 8'd0;
    end
    idle_pct        = 32;
    sent_words      = 0;
    loads_sent      = 0;
    queries_sent    = 0;
    results_checked = 0;
    reg_writes      = 0;
    mismatches      = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset registers first: 256x256 grid, spacing ~0.2,
    // inverse 5.0, gain ~0.1, bias -5. Half extent is 1677696 on both axes.
    // Flat corner of cell (0,0): height is the bias alone.
    add_row(load_row(8'd0, 16'd0));
    add_row(load_row(8'd0, 16'd1));
    add_row(load_row(8'd0, 16'd256));
    add_row(load_row(8'd0, 16'd257));
    add_row(checked_row(-32'sd1677696, 32'sd1677696,
                        '{height: RST_HEIGHT_BIAS, off_grid: 1'b0, lower: 1'b0}));
    // coordinate extremes, all off the grid
    add_row(checked_row(32'h8000_0000, 32'd0, OFF_GRID_RESULT));
    add_row(checked_row(32'h7FFF_FFFF, 32'd0, OFF_GRID_RESULT));
    add_row(checked_row(32'd0, 32'h8000_0000, OFF_GRID_RESULT));
    add_row(checked_row(32'd0, 32'h7FFF_FFFF, OFF_GRID_RESULT));
    // one LSB left of the grid: floor must give cell -1, not 0
    add_row(checked_row(-32'sd1677697, 32'd0, OFF_GRID_RESULT));
    // far edge lands in the last column, which has no right neighbor
    add_row(checked_row(32'sd1677696, 32'd0, OFF_GRID_RESULT));
    // top of the store and top sample value
    add_row(load_row(8'd255, 16'hFFFF));
    // world origin: cell (127,127), fractions near one -> lower-right triangle
    add_row(load_row(8'd255, 16'd32639));
    add_row(load_row(8'd0,   16'd32640));
    add_row(load_row(8'd128, 16'd32895));
    add_row(load_row(8'd200, 16'd32896));
    add_row(query_row(32'd0, 32'd0));
    // Unit grid 4x4, heights equal to samples: exact fractions.
    add_row(reg_row(REG_GRID_WIDTH,   32'd4));
    add_row(reg_row(REG_GRID_DEPTH,   32'd4));
    add_row(reg_row(REG_CELL_SPACING, 32'd65536));
    add_row(reg_row(REG_CELL_INVERSE, 32'd65536));
    add_row(reg_row(REG_HEIGHT_GAIN,  32'd65536));
    add_row(reg_row(REG_HEIGHT_BIAS,  32'd0));
    add_row(load_row(8'd100, 16'd1));
    add_row(load_row(8'd200, 16'd4));
    add_row(load_row(8'd50,  16'd5));
    // fx+fz exactly one stays upper; one LSB more flips to lower
    add_row(query_row(-32'sd98304, 32'sd98304));
    add_row(query_row(-32'sd98303, 32'sd98303));
    // top gain and bias: climbing from the bias overflows and must clamp
    add_row(reg_row(REG_HEIGHT_GAIN, 32'h00FF_FFFF));
    add_row(reg_row(REG_HEIGHT_BIAS, 32'h7FFF_FFFF));
    add_row(query_row(-32'sd98304, 32'sd98304));

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_reg)
        write_reg(plan_rows[i].sel, plan_rows[i].data);
      else if (plan_rows[i].op == OP_LOAD)
        send_word(OP_LOAD, plan_rows[i].val, plan_rows[i].idx, plan_rows[i].wx,
                  plan_rows[i].wz, 1'b0, '0);
      else
        issue_query(plan_rows[i].wx, plan_rows[i].wz, plan_rows[i].typed, plan_rows[i].want);
    end

    // Random part. Setups walk from the smallest grid to oversize and
    // inconsistent ones, hitting each register's limits on the way.
    random_base = sent_words;
    run_phase(make_setup(9'd2, 9'd2, 21'd65536, 25'd65536, 24'($urandom), $urandom),
              random_base);
    run_phase(make_setup(9'd256, 9'd256, 21'd13107, 25'd327680, 24'd6554, 32'hFFFB_0000),
              random_base);
    // smallest spacing, largest inverse, top gain and bias
    run_phase(make_setup(9'd16, 9'd9, 21'd256, 25'h100_0000, 24'hFF_FFFF, 32'h7FFF_FFFF),
              random_base);
    // largest spacing, zero gain, most negative bias
    run_phase(make_setup(9'd7, 9'd3, 21'h10_0000, 25'd4096, 24'd0, 32'h8000_0000),
              random_base);
    // zero width: nothing is ever on the grid
    run_phase(make_setup(9'd0, 9'd511, 21'($urandom), 25'($urandom), 24'($urandom), $urandom),
              random_base);
    // oversize grid: corner addresses wrap around the store
    run_phase(make_setup(9'd400, 9'd300, 21'd256, 25'h100_0000, 24'($urandom), $urandom),
              random_base);
    sp = 21'($urandom_range(256, 1 << 20));
    run_phase(make_setup(9'($urandom_range(2, 32)), 9'($urandom_range(2, 32)), sp,
                         25'(64'h1_0000_0000 / sp), 24'($urandom), $urandom),
              random_base);
    // inverse unrelated to the spacing
    run_phase(make_setup(9'($urandom_range(2, 40)), 9'($urandom_range(2, 40)),
                         21'($urandom_range(256, 1 << 20)),
                         25'($urandom_range(1, (1 << 25) - 1)), 24'($urandom), $urandom),
              random_base);

    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d loads, %0d queries) across %0d register writes;",
             sent_words, loads_sent, queries_sent, reg_writes);
    $display("checked %0d result words, %0d mismatched.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/thl_pkg.sv
rtl/thl_store.sv
rtl/thl_queue.sv
rtl/thl_front.sv
rtl/thl_back.sv
rtl/terrain_height_lookup.sv
verif/tb_terrain_height_lookup.sv
